// ----- rtl/psp_pkg.sv -----
// Shared types, codes and helpers for the produce response stream parser.
// Used by every module in this folder; depends on nothing else.
`default_nettype none

package psp_pkg;

  typedef enum logic [3:0] {
    PH_SIZE   = 4'd0,
    PH_CORR   = 4'd1,
    PH_TCOUNT = 4'd2,
    PH_NLEN   = 4'd3,
    PH_NAME   = 4'd4,
    PH_PCOUNT = 4'd5,
    PH_PREC   = 4'd6,
    PH_TAIL   = 4'd7,
    PH_IDLE   = 4'd8
  } psp_phase_t;

  localparam logic [2:0] K_HEADER = 3'd0;
  localparam logic [2:0] K_NAMECH = 3'd1;
  localparam logic [2:0] K_TOPIC  = 3'd2;
  localparam logic [2:0] K_PART   = 3'd3;
  localparam logic [2:0] K_DONE   = 3'd4;
  localparam logic [2:0] K_ERROR  = 3'd5;

  localparam logic [2:0] S_OK    = 3'd0;
  localparam logic [2:0] S_SHORT = 3'd1;
  localparam logic [2:0] S_TRUNC = 3'd2;
  localparam logic [2:0] S_BADTC = 3'd3;
  localparam logic [2:0] S_BADNL = 3'd4;
  localparam logic [2:0] S_BADPC = 3'd5;

  localparam logic [3:0] FIELD4_BYTES = 4'd4;
  localparam logic [3:0] NLEN_BYTES   = 4'd2;
  localparam logic [3:0] REC_BYTES    = 4'd14;
  localparam logic [3:0] REC_HEAD_END = 4'd8;

  // A byte gives at most two results: one ordinary result followed by done or an error.
  localparam int MAX_RES      = 2;
  localparam int RES_CNT_W    = 2;
  localparam int QUEUE_ADDR_W = 2;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  status;
    logic [30:0] topic_number;
    logic [14:0] name_length;
    logic [7:0]  name_char;
    logic [30:0] item_count;
    logic [30:0] partition_slot;
    logic [31:0] partition_id;
    logic [15:0] partition_status;
    logic [63:0] log_offset;
    logic [31:0] correlation_tag;
    logic        last_of_run;
  } psp_result_t;

  function automatic psp_result_t make_result(input logic [2:0] k, input logic [2:0] s);
    psp_result_t r;
    r = '0;
    r.kind = k;
    r.status = s;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/psp_step.sv -----
// Parser state and the per-byte step logic that yields up to two results.
// Depends on psp_pkg.
`default_nettype none

module psp_step (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 fire,
  input  wire logic [7:0]                           data_byte,
  input  wire logic                                 last_byte,
  output logic [psp_pkg::RES_CNT_W-1:0]             res_count,
  output psp_pkg::psp_result_t [psp_pkg::MAX_RES-1:0] results
);

  psp_pkg::psp_phase_t phase, phase_next;
  logic [31:0] bytes_seen, bytes_seen_next;
  logic [32:0] declared_total, declared_total_next;
  logic [63:0] field_shift, field_shift_next;
  logic [3:0]  field_bytes_left, field_bytes_left_next;
  logic [30:0] topics_total, topics_total_next;
  logic [30:0] topic_counter, topic_counter_next;
  logic [30:0] partitions_total, partitions_total_next;
  logic [30:0] partition_counter, partition_counter_next;
  logic [14:0] name_bytes_left, name_bytes_left_next;
  logic [31:0] saved_tag, saved_tag_next;
  logic [47:0] saved_fields, saved_fields_next;
  logic [14:0] topic_name_length, topic_name_length_next;

  logic [31:0] bytes_inc;
  logic [31:0] word32;
  logic [15:0] nlen_word;
  logic        nlen_null;
  logic [14:0] nlen_val;
  logic        seen_ge_total;
  logic        seen_lt_total;
  logic        nlen_over;
  logic        topic_over;
  logic        rec_over;
  logic        go_part;
  logic        go_topic;
  logic [3:0]  fbl_dec;
  logic [psp_pkg::RES_CNT_W-1:0] res_n;
  psp_pkg::psp_result_t [psp_pkg::MAX_RES-1:0] res_v;

  localparam logic [psp_pkg::RES_CNT_W-1:0] RES_ONE = psp_pkg::RES_CNT_W'(1);
  localparam logic [psp_pkg::RES_CNT_W-1:0] RES_TWO = psp_pkg::RES_CNT_W'(2);

  assign bytes_inc     = (bytes_seen == '1) ? bytes_seen : bytes_seen + 32'd1;
  assign word32        = {field_shift[23:0], data_byte};
  assign nlen_word     = {field_shift[7:0], data_byte};
  assign nlen_null     = (nlen_word == 16'hFFFF);
  assign nlen_val      = nlen_null ? 15'd0 : nlen_word[14:0];
  assign seen_ge_total = ({1'b0, bytes_inc} >= declared_total);
  assign seen_lt_total = !seen_ge_total;
  assign nlen_over     = ({2'b00, bytes_inc} + {19'd0, nlen_val} + 34'd4) >
                         {1'b0, declared_total};
  assign topic_over    = ({2'b00, bytes_inc} + 34'd2) > {1'b0, declared_total};
  assign rec_over      = ({2'b00, bytes_inc} + 34'd14) > {1'b0, declared_total};
  assign fbl_dec       = (field_bytes_left != 4'd0) ? field_bytes_left - 4'd1 : 4'd0;

  always_comb begin
    phase_next             = phase;
    bytes_seen_next        = bytes_seen;
    declared_total_next    = declared_total;
    field_shift_next       = field_shift;
    field_bytes_left_next  = field_bytes_left;
    topics_total_next      = topics_total;
    topic_counter_next     = topic_counter;
    partitions_total_next  = partitions_total;
    partition_counter_next = partition_counter;
    name_bytes_left_next   = name_bytes_left;
    saved_tag_next         = saved_tag;
    saved_fields_next      = saved_fields;
    topic_name_length_next = topic_name_length;
    res_n    = '0;
    res_v    = '0;
    go_part  = 1'b0;
    go_topic = 1'b0;

    if (phase != psp_pkg::PH_IDLE) begin
      bytes_seen_next = bytes_inc;
      if (last_byte && phase >= psp_pkg::PH_NLEN && seen_lt_total) begin
        res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
        res_n = res_n + RES_ONE;
        phase_next = psp_pkg::PH_IDLE;
      end else begin
        case (phase)
          psp_pkg::PH_SIZE, psp_pkg::PH_CORR, psp_pkg::PH_TCOUNT: begin
            field_shift_next = {32'd0, word32};
            field_bytes_left_next = fbl_dec;
            if (fbl_dec != 4'd0 || phase != psp_pkg::PH_TCOUNT) begin
              if (fbl_dec == 4'd0) begin
                if (phase == psp_pkg::PH_SIZE) begin
                  declared_total_next = {1'b0, word32} + 33'd4;
                  phase_next = psp_pkg::PH_CORR;
                end else begin
                  saved_tag_next = word32;
                  phase_next = psp_pkg::PH_TCOUNT;
                end
                field_bytes_left_next = psp_pkg::FIELD4_BYTES;
                field_shift_next = '0;
              end
              if (last_byte) begin
                res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_SHORT);
                res_n = res_n + RES_ONE;
                phase_next = psp_pkg::PH_IDLE;
              end
            end else if (last_byte && seen_lt_total) begin
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
              res_n = res_n + RES_ONE;
              phase_next = psp_pkg::PH_IDLE;
            end else if (word32[31]) begin
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_BADTC);
              res_n = res_n + RES_ONE;
              phase_next = psp_pkg::PH_IDLE;
            end else begin
              topics_total_next = word32[30:0];
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_HEADER, psp_pkg::S_OK);
              res_v[res_n[0]].item_count = word32[30:0];
              res_v[res_n[0]].correlation_tag = saved_tag;
              res_n = res_n + RES_ONE;
              topic_counter_next = '0;
              go_topic = 1'b1;
            end
          end
          psp_pkg::PH_NLEN: begin
            field_shift_next = {48'd0, nlen_word};
            field_bytes_left_next = fbl_dec;
            if (fbl_dec == 4'd0) begin
              if (!nlen_null && nlen_word[15]) begin
                res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_BADNL);
                res_n = res_n + RES_ONE;
                phase_next = psp_pkg::PH_IDLE;
              end else begin
                topic_name_length_next = nlen_val;
                if (nlen_over) begin
                  res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
                  res_n = res_n + RES_ONE;
                  phase_next = psp_pkg::PH_IDLE;
                end else begin
                  name_bytes_left_next = nlen_val;
                  if (nlen_val != 15'd0) begin
                    phase_next = psp_pkg::PH_NAME;
                  end else begin
                    phase_next = psp_pkg::PH_PCOUNT;
                    field_bytes_left_next = psp_pkg::FIELD4_BYTES;
                    field_shift_next = '0;
                  end
                end
              end
            end
          end
          psp_pkg::PH_NAME: begin
            res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_NAMECH, psp_pkg::S_OK);
            res_v[res_n[0]].topic_number = topic_counter;
            res_v[res_n[0]].name_length = topic_name_length;
            res_v[res_n[0]].name_char = data_byte;
            res_n = res_n + RES_ONE;
            if (name_bytes_left <= 15'd1) begin
              name_bytes_left_next = '0;
              phase_next = psp_pkg::PH_PCOUNT;
              field_bytes_left_next = psp_pkg::FIELD4_BYTES;
              field_shift_next = '0;
            end else begin
              name_bytes_left_next = name_bytes_left - 15'd1;
            end
          end
          psp_pkg::PH_PCOUNT: begin
            field_shift_next = {32'd0, word32};
            field_bytes_left_next = fbl_dec;
            if (fbl_dec == 4'd0) begin
              if (word32[31]) begin
                res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_BADPC);
                res_n = res_n + RES_ONE;
                phase_next = psp_pkg::PH_IDLE;
              end else begin
                partitions_total_next = word32[30:0];
                res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_TOPIC, psp_pkg::S_OK);
                res_v[res_n[0]].topic_number = topic_counter;
                res_v[res_n[0]].name_length = topic_name_length;
                res_v[res_n[0]].item_count = word32[30:0];
                res_n = res_n + RES_ONE;
                partition_counter_next = '0;
                go_part = 1'b1;
              end
            end
          end
          psp_pkg::PH_PREC: begin
            if (field_bytes_left > psp_pkg::REC_HEAD_END) begin
              saved_fields_next = {saved_fields[39:0], data_byte};
            end else begin
              field_shift_next = {field_shift[55:0], data_byte};
            end
            field_bytes_left_next = fbl_dec;
            if (fbl_dec == 4'd0) begin
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_PART, psp_pkg::S_OK);
              res_v[res_n[0]].topic_number = topic_counter;
              res_v[res_n[0]].partition_slot = partition_counter;
              res_v[res_n[0]].partition_id = saved_fields_next[47:16];
              res_v[res_n[0]].partition_status = saved_fields_next[15:0];
              res_v[res_n[0]].log_offset = field_shift_next;
              res_n = res_n + RES_ONE;
              partition_counter_next = partition_counter + 31'd1;
              go_part = 1'b1;
            end
          end
          psp_pkg::PH_TAIL: begin
            if (seen_ge_total) begin
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_DONE, psp_pkg::S_OK);
              res_n = res_n + RES_ONE;
              phase_next = psp_pkg::PH_IDLE;
            end
          end
          default: begin
          end
        endcase

        if (go_part) begin
          if (partition_counter_next >= partitions_total_next) begin
            topic_counter_next = topic_counter_next + 31'd1;
            go_topic = 1'b1;
          end else if (rec_over) begin
            res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
            res_n = res_n + RES_ONE;
            phase_next = psp_pkg::PH_IDLE;
          end else begin
            phase_next = psp_pkg::PH_PREC;
            field_bytes_left_next = psp_pkg::REC_BYTES;
            field_shift_next = '0;
            saved_fields_next = '0;
          end
        end

        if (go_topic) begin
          if (topic_counter_next >= topics_total_next) begin
            if (seen_ge_total) begin
              res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_DONE, psp_pkg::S_OK);
              res_n = res_n + RES_ONE;
              phase_next = psp_pkg::PH_IDLE;
            end else begin
              phase_next = psp_pkg::PH_TAIL;
            end
          end else if (topic_over) begin
            res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
            res_n = res_n + RES_ONE;
            phase_next = psp_pkg::PH_IDLE;
          end else begin
            phase_next = psp_pkg::PH_NLEN;
            field_bytes_left_next = psp_pkg::NLEN_BYTES;
            field_shift_next = '0;
          end
        end
      end

      if (last_byte && phase_next != psp_pkg::PH_IDLE) begin
        res_v[res_n[0]] = psp_pkg::make_result(psp_pkg::K_ERROR, psp_pkg::S_TRUNC);
        res_n = res_n + RES_ONE;
        phase_next = psp_pkg::PH_IDLE;
      end
    end

    if (last_byte) begin
      phase_next             = psp_pkg::PH_SIZE;
      bytes_seen_next        = '0;
      declared_total_next    = '0;
      field_shift_next       = '0;
      field_bytes_left_next  = psp_pkg::FIELD4_BYTES;
      topics_total_next      = '0;
      topic_counter_next     = '0;
      partitions_total_next  = '0;
      partition_counter_next = '0;
      name_bytes_left_next   = '0;
      saved_tag_next         = '0;
      saved_fields_next      = '0;
      topic_name_length_next = '0;
    end

    if (res_n == RES_TWO) begin
      res_v[1].last_of_run = 1'b1;
    end else if (res_n == RES_ONE) begin
      res_v[0].last_of_run = 1'b1;
    end
  end

  assign res_count = res_n;
  assign results   = res_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= psp_pkg::PH_SIZE;
      bytes_seen        <= '0;
      declared_total    <= '0;
      field_shift       <= '0;
      field_bytes_left  <= psp_pkg::FIELD4_BYTES;
      topics_total      <= '0;
      topic_counter     <= '0;
      partitions_total  <= '0;
      partition_counter <= '0;
      name_bytes_left   <= '0;
      saved_tag         <= '0;
      saved_fields      <= '0;
      topic_name_length <= '0;
    end else if (fire) begin
      phase             <= phase_next;
      bytes_seen        <= bytes_seen_next;
      declared_total    <= declared_total_next;
      field_shift       <= field_shift_next;
      field_bytes_left  <= field_bytes_left_next;
      topics_total      <= topics_total_next;
      topic_counter     <= topic_counter_next;
      partitions_total  <= partitions_total_next;
      partition_counter <= partition_counter_next;
      name_bytes_left   <= name_bytes_left_next;
      saved_tag         <= saved_tag_next;
      saved_fields      <= saved_fields_next;
      topic_name_length <= topic_name_length_next;
    end
  end

  // Done and error always close the run of results for a byte.
  a_final_result: assert property (@(posedge clk) disable iff (rst)
    (fire && res_count == RES_TWO) |->
      (results[0].kind != psp_pkg::K_ERROR && results[0].kind != psp_pkg::K_DONE))
    else $error("done or error result followed by another result");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    (fire && last_byte) |=> (phase == psp_pkg::PH_SIZE && bytes_seen == '0))
    else $error("parser did not restart after the final byte");

endmodule

`default_nettype wire

// ----- rtl/psp_result_queue.sv -----
// Small result queue that takes up to two results per cycle and hands out one.
// Depends on psp_pkg.
`default_nettype none

module psp_result_queue #(
  parameter int ADDR_W = psp_pkg::QUEUE_ADDR_W
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic [psp_pkg::RES_CNT_W-1:0]          push_count,
  input  wire psp_pkg::psp_result_t [psp_pkg::MAX_RES-1:0] push_data,
  input  wire logic                                   pop,
  output psp_pkg::psp_result_t                        head,
  output logic                                        not_empty,
  output logic                                        room
);

  localparam int DEPTH = 1 << ADDR_W;
  localparam int CW    = ADDR_W + 1;

  psp_pkg::psp_result_t entries [DEPTH];
  logic [ADDR_W-1:0] wr_ptr, wr_ptr_next;
  logic [ADDR_W-1:0] rd_ptr;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     count_after_pop;

  assign count_after_pop = count - CW'(pop);
  assign count_next      = count_after_pop + CW'(push_count);
  assign wr_ptr_next     = wr_ptr + ADDR_W'(push_count);
  assign room            = (count_after_pop <= CW'(DEPTH - psp_pkg::MAX_RES));
  assign not_empty       = (count != '0);
  assign head            = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int k = 0; k < psp_pkg::MAX_RES; k++) begin
      if (push_count > psp_pkg::RES_CNT_W'(k)) begin
        entries[wr_ptr + ADDR_W'(k)] <= push_data[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + ADDR_W'(1);
      end
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue holds more entries than it has");

  a_full_no_push: assert property (@(posedge clk) disable iff (rst)
    (count == CW'(DEPTH) && !pop) |-> (push_count == '0))
    else $error("push into a full result queue");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty result queue");

endmodule

`default_nettype wire

// ----- rtl/produce_response_stream_parser.sv -----
// Top level of the produce response stream parser: input register, step logic and result queue.
// Depends on psp_pkg, psp_step and psp_result_queue.
//
//   Channel  Direction  Handshake           Payload
//   in       to block   in_valid/in_stall   data_byte, last_byte
//   out      from block out_valid/out_stall kind, status, topic_number ... last_of_run
//
// One byte is taken per cycle unless stalled; its results enter the queue as the byte fires.
// Each byte yields zero, one or two results; output moves one result per cycle unless stalled,
// so bytes that give two results slow the input only once the queue fills.
// The input stalls when the queue cannot take two more results in the same cycle.
// Reset is synchronous; there is no clearing pass.
`default_nettype none

module produce_response_stream_parser #(
  parameter int QUEUE_ADDR_W = psp_pkg::QUEUE_ADDR_W
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last_byte,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [2:0]              kind,
  output logic [2:0]              status,
  output logic [30:0]             topic_number,
  output logic [14:0]             name_length,
  output logic [7:0]              name_char,
  output logic [30:0]             item_count,
  output logic [30:0]             partition_slot,
  output logic signed [31:0]      partition_id,
  output logic signed [15:0]      partition_status,
  output logic signed [63:0]      log_offset,
  output logic signed [31:0]      correlation_tag,
  output logic                    last_of_run
);

  logic       in_reg_valid;
  logic [7:0] in_reg_byte;
  logic       in_reg_last;
  logic       fire;
  logic       accept;
  logic       pop;
  logic       room;
  logic [psp_pkg::RES_CNT_W-1:0] res_count;
  logic [psp_pkg::RES_CNT_W-1:0] push_count;
  psp_pkg::psp_result_t [psp_pkg::MAX_RES-1:0] results;
  psp_pkg::psp_result_t head;

  assign fire       = in_reg_valid && room;
  assign in_stall   = in_reg_valid && !room;
  assign accept     = in_valid && !in_stall;
  assign pop        = out_valid && !out_stall;
  assign push_count = fire ? res_count : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (fire) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_reg_byte <= data_byte;
      in_reg_last <= last_byte;
    end
  end

  psp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_reg_byte),
    .last_byte (in_reg_last),
    .res_count (res_count),
    .results   (results)
  );

  psp_result_queue #(
    .ADDR_W (QUEUE_ADDR_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push_data  (results),
    .pop        (pop),
    .head       (head),
    .not_empty  (out_valid),
    .room       (room)
  );

  assign kind             = head.kind;
  assign status           = head.status;
  assign topic_number     = head.topic_number;
  assign name_length      = head.name_length;
  assign name_char        = head.name_char;
  assign item_count       = head.item_count;
  assign partition_slot   = head.partition_slot;
  assign partition_id     = head.partition_id;
  assign partition_status = head.partition_status;
  assign log_offset       = head.log_offset;
  assign correlation_tag  = head.correlation_tag;
  assign last_of_run      = head.last_of_run;

  a_held_byte: assert property (@(posedge clk) disable iff (rst)
    (in_reg_valid && !fire) |=>
      (in_reg_valid && $stable(in_reg_byte) && $stable(in_reg_last)))
    else $error("held input byte was lost or changed");

endmodule

`default_nettype wire

// ----- bench/tb_produce_response_stream_parser.sv -----
// Self-checking bench for the produce response stream parser: response frames go in as bytes,
// and every result is checked against a predictor of the parser kept inside the bench.
// Depends on psp_pkg and produce_response_stream_parser.
module tb_produce_response_stream_parser;

  localparam int RANDOM_BYTES = 300;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_byte_t;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_COMB, FLOW_HEAVY} flow_t;

  typedef enum int {
    SHAPE_CLEAN, SHAPE_CUT, SHAPE_BAD_NAME, SHAPE_BAD_PARTS, SHAPE_BAD_TOPICS, SHAPE_ODD
  } shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'd0;
  logic last_byte = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] kind;
  logic [2:0] status;
  logic [30:0] topic_number;
  logic [14:0] name_length;
  logic [7:0] name_char;
  logic [30:0] item_count;
  logic [30:0] partition_slot;
  logic signed [31:0] partition_id;
  logic signed [15:0] partition_status;
  logic signed [63:0] log_offset;
  logic signed [31:0] correlation_tag;
  logic last_of_run;

  produce_response_stream_parser uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .kind(kind),
    .status(status),
    .topic_number(topic_number),
    .name_length(name_length),
    .name_char(name_char),
    .item_count(item_count),
    .partition_slot(partition_slot),
    .partition_id(partition_id),
    .partition_status(partition_status),
    .log_offset(log_offset),
    .correlation_tag(correlation_tag),
    .last_of_run(last_of_run)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Parser state as the bench tracks it.
  psp_pkg::psp_phase_t rx_phase;
  logic [31:0] rx_seen;
  logic [32:0] rx_end;
  logic [63:0] rx_shift;
  logic [3:0] rx_left;
  logic [31:0] rx_topics;
  logic [31:0] rx_topic;
  logic [31:0] rx_parts;
  logic [31:0] rx_part;
  logic [14:0] rx_name_left;
  logic [31:0] rx_tag;
  logic [47:0] rx_rec_head;
  logic [14:0] rx_name_len;

  psp_pkg::psp_result_t byte_results[$];
  psp_pkg::psp_result_t pending_results[$];

  task automatic clear_stream;
    rx_phase = psp_pkg::PH_SIZE;
    rx_seen = 32'd0;
    rx_end = 33'd0;
    rx_shift = 64'd0;
    rx_left = psp_pkg::FIELD4_BYTES;
    rx_topics = 32'd0;
    rx_topic = 32'd0;
    rx_parts = 32'd0;
    rx_part = 32'd0;
    rx_name_left = 15'd0;
    rx_tag = 32'd0;
    rx_rec_head = 48'd0;
    rx_name_len = 15'd0;
  endtask

  task automatic raise_error(input logic [2:0] s);
    psp_pkg::psp_result_t r;
    r = '0;
    r.kind = psp_pkg::K_ERROR;
    r.status = s;
    byte_results.push_back(r);
    rx_phase = psp_pkg::PH_IDLE;
  endtask

  task automatic close_ok;
    psp_pkg::psp_result_t r;
    r = '0;
    r.kind = psp_pkg::K_DONE;
    r.status = psp_pkg::S_OK;
    byte_results.push_back(r);
    rx_phase = psp_pkg::PH_IDLE;
  endtask

  task automatic open_field(input psp_pkg::psp_phase_t p, input logic [3:0] n);
    rx_phase = p;
    rx_left = n;
    rx_shift = 64'd0;
  endtask

  task automatic start_topic;
    if (rx_topic >= rx_topics) begin
      if (rx_seen >= rx_end) close_ok();
      else rx_phase = psp_pkg::PH_TAIL;
    end else if (rx_seen + 34'd2 > rx_end) begin
      raise_error(psp_pkg::S_TRUNC);
    end else begin
      open_field(psp_pkg::PH_NLEN, psp_pkg::NLEN_BYTES);
    end
  endtask

  task automatic step_partition;
    if (rx_part >= rx_parts) begin
      rx_topic = rx_topic + 32'd1;
      start_topic();
    end else if (rx_seen + 34'd14 > rx_end) begin
      raise_error(psp_pkg::S_TRUNC);
    end else begin
      open_field(psp_pkg::PH_PREC, psp_pkg::REC_BYTES);
      rx_rec_head = 48'd0;
    end
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic fin);
    psp_pkg::psp_result_t r;
    logic [3:0] pos;
    int k;
    byte_results.delete();
    if (rx_phase != psp_pkg::PH_IDLE) begin
      if (rx_seen != 32'hFFFF_FFFF) rx_seen = rx_seen + 32'd1;
      if (fin && rx_phase >= psp_pkg::PH_NLEN && rx_seen < rx_end) begin
        raise_error(psp_pkg::S_TRUNC);
      end else begin
        case (rx_phase)
          psp_pkg::PH_SIZE, psp_pkg::PH_CORR, psp_pkg::PH_TCOUNT: begin
            rx_shift = {32'd0, rx_shift[23:0], b};
            if (rx_left != 4'd0) rx_left = rx_left - 4'd1;
            if (rx_left != 4'd0 || rx_phase != psp_pkg::PH_TCOUNT) begin
              if (rx_left == 4'd0) begin
                if (rx_phase == psp_pkg::PH_SIZE) rx_end = {1'b0, rx_shift[31:0]} + 33'd4;
                else rx_tag = rx_shift[31:0];
                open_field(psp_pkg::psp_phase_t'(rx_phase + 4'd1), psp_pkg::FIELD4_BYTES);
              end
              if (fin) raise_error(psp_pkg::S_SHORT);
            end else if (fin && rx_end > rx_seen) begin
              raise_error(psp_pkg::S_TRUNC);
            end else if (rx_shift[31]) begin
              raise_error(psp_pkg::S_BADTC);
            end else begin
              rx_topics = rx_shift[31:0];
              r = '0;
              r.kind = psp_pkg::K_HEADER;
              r.status = psp_pkg::S_OK;
              r.item_count = rx_shift[30:0];
              r.correlation_tag = rx_tag;
              byte_results.push_back(r);
              rx_topic = 32'd0;
              start_topic();
            end
          end
          psp_pkg::PH_NLEN: begin
            rx_shift = {48'd0, rx_shift[7:0], b};
            if (rx_left != 4'd0) rx_left = rx_left - 4'd1;
            if (rx_left == 4'd0) begin
              if (rx_shift[15] && rx_shift[15:0] != 16'hFFFF) begin
                raise_error(psp_pkg::S_BADNL);
              end else begin
                rx_name_len = (rx_shift[15:0] == 16'hFFFF) ? 15'd0 : rx_shift[14:0];
                if (rx_seen + rx_name_len + 34'd4 > rx_end) begin
                  raise_error(psp_pkg::S_TRUNC);
                end else begin
                  rx_name_left = rx_name_len;
                  if (rx_name_len != 15'd0) rx_phase = psp_pkg::PH_NAME;
                  else open_field(psp_pkg::PH_PCOUNT, psp_pkg::FIELD4_BYTES);
                end
              end
            end
          end
          psp_pkg::PH_NAME: begin
            r = '0;
            r.kind = psp_pkg::K_NAMECH;
            r.status = psp_pkg::S_OK;
            r.topic_number = rx_topic[30:0];
            r.name_length = rx_name_len;
            r.name_char = b;
            byte_results.push_back(r);
            if (rx_name_left != 15'd0) rx_name_left = rx_name_left - 15'd1;
            if (rx_name_left == 15'd0) open_field(psp_pkg::PH_PCOUNT, psp_pkg::FIELD4_BYTES);
          end
          psp_pkg::PH_PCOUNT: begin
            rx_shift = {32'd0, rx_shift[23:0], b};
            if (rx_left != 4'd0) rx_left = rx_left - 4'd1;
            if (rx_left == 4'd0) begin
              if (rx_shift[31]) begin
                raise_error(psp_pkg::S_BADPC);
              end else begin
                rx_parts = rx_shift[31:0];
                r = '0;
                r.kind = psp_pkg::K_TOPIC;
                r.status = psp_pkg::S_OK;
                r.topic_number = rx_topic[30:0];
                r.name_length = rx_name_len;
                r.item_count = rx_shift[30:0];
                byte_results.push_back(r);
                rx_part = 32'd0;
                step_partition();
              end
            end
          end
          psp_pkg::PH_PREC: begin
            pos = psp_pkg::REC_BYTES - rx_left;
            if (pos < 4'd6) rx_rec_head = {rx_rec_head[39:0], b};
            else rx_shift = {rx_shift[55:0], b};
            if (rx_left != 4'd0) rx_left = rx_left - 4'd1;
            if (rx_left == 4'd0) begin
              r = '0;
              r.kind = psp_pkg::K_PART;
              r.status = psp_pkg::S_OK;
              r.topic_number = rx_topic[30:0];
              r.partition_slot = rx_part[30:0];
              r.partition_id = rx_rec_head[47:16];
              r.partition_status = rx_rec_head[15:0];
              r.log_offset = rx_shift;
              byte_results.push_back(r);
              rx_part = rx_part + 32'd1;
              step_partition();
            end
          end
          psp_pkg::PH_TAIL: begin
            if (rx_seen >= rx_end) close_ok();
          end
          default: begin
          end
        endcase
      end
      if (fin && rx_phase != psp_pkg::PH_IDLE) raise_error(psp_pkg::S_TRUNC);
    end
    if (fin) clear_stream();
    for (k = 0; k < byte_results.size(); k++) begin
      r = byte_results[k];
      r.last_of_run = (k == byte_results.size() - 1);
      pending_results.push_back(r);
    end
  endtask

  // Frame assembly.
  logic [7:0] frame[$];
  stream_byte_t feed[$];
  int random_count = 0;
  int feed_total = 0;

  task automatic put_be(input logic [63:0] v, input int n);
    int i;
    for (i = n - 1; i >= 0; i--) frame.push_back(v[8*i +: 8]);
  endtask

  task automatic queue_frame(input int over, input int cut);
    int i;
    stream_byte_t w;
    for (i = 0; i < over; i++) frame.push_back(8'($urandom_range(0, 255)));
    for (i = 0; i < cut && frame.size() > 1; i++) frame.delete(frame.size() - 1);
    random_count += frame.size() - over;
    for (i = 0; i < frame.size(); i++) begin
      w.data = frame[i];
      w.fin = (i == frame.size() - 1);
      feed.push_back(w);
    end
    frame.delete();
  endtask

  task automatic add_response;
    shape_t shape;
    int roll, ntop, bad_t, t, p, i, nl, np, pad, over, cut;
    logic [15:0] nl_field;
    logic [31:0] pc_field, size_field;
    roll = $urandom_range(0, 9);
    shape = (roll < 5) ? SHAPE_CLEAN : shape_t'(roll - 4);
    frame.delete();
    if (shape == SHAPE_ODD && $urandom_range(0, 1) == 1) begin
      np = $urandom_range(1, 16);
      for (i = 0; i < np; i++) frame.push_back(8'($urandom_range(0, 255)));
      queue_frame(0, 0);
      return;
    end
    ntop = $urandom_range(0, 2);
    if (shape == SHAPE_BAD_NAME || shape == SHAPE_BAD_PARTS) ntop = $urandom_range(1, 2);
    if (shape == SHAPE_BAD_TOPICS) ntop = 0;
    bad_t = (ntop > 0) ? $urandom_range(0, ntop - 1) : 0;
    put_be(64'($urandom), 4);
    if (shape == SHAPE_BAD_TOPICS) put_be(64'({1'b1, 31'($urandom)}), 4);
    else put_be(64'(ntop), 4);
    for (t = 0; t < ntop; t++) begin
      nl = $urandom_range(0, 3);
      if (shape == SHAPE_BAD_NAME && t == bad_t) begin
        if ($urandom_range(0, 1) == 1) nl_field = {1'b1, 15'($urandom_range(0, 16'h7FFE))};
        else nl_field = 16'h7FFF;
        nl = 0;
      end else if ($urandom_range(0, 4) == 0) begin
        nl_field = 16'hFFFF;
        nl = 0;
      end else begin
        nl_field = 16'(nl);
      end
      put_be(64'(nl_field), 2);
      for (i = 0; i < nl; i++) frame.push_back(8'($urandom_range(0, 255)));
      np = $urandom_range(0, 2);
      if (shape == SHAPE_BAD_PARTS && t == bad_t) pc_field = {1'b1, 31'($urandom)};
      else pc_field = 32'(np);
      put_be(64'(pc_field), 4);
      for (p = 0; p < np; p++)
        for (i = 0; i < 14; i++) frame.push_back(8'($urandom_range(0, 255)));
    end
    pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < pad; i++) frame.push_back(8'($urandom_range(0, 255)));
    size_field = frame.size();
    over = 0;
    cut = 0;
    if (shape == SHAPE_CUT) begin
      if ($urandom_range(0, 1) == 1) size_field = frame.size() - $urandom_range(1, frame.size());
      else cut = $urandom_range(1, frame.size() + 3);
    end else if (shape == SHAPE_ODD) begin
      size_field = 32'hFFFF_FFFF - $urandom_range(0, 3);
    end else if ($urandom_range(0, 2) == 0) begin
      over = $urandom_range(1, 3);
    end
    for (i = 0; i < 4; i++) frame.push_front(size_field[8*i +: 8]);
    queue_frame(over, cut);
  endtask

  // Sender: bursts of transfers separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  int bytes_taken = 0;
  stream_byte_t next_byte;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        parse_byte(data_byte, last_byte);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0 || feed.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          next_byte = feed.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_byte.data;
          last_byte <= next_byte.fin;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 60);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end
        end
      end
    end
  end

  // Receiver stall pattern, picked at random among free, light, comb and heavy flow.
  flow_t flow = FLOW_FREE;
  int flow_tick = 0;

  always @(posedge clk) begin
    flow_tick++;
    if (flow_tick % 50 == 0) flow = flow_t'($urandom_range(0, 3));
    case (flow)
      FLOW_FREE: out_stall <= 1'b0;
      FLOW_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      FLOW_COMB: out_stall <= (flow_tick % 3 != 0);
      default: out_stall <= ($urandom_range(0, 9) < 7);
    endcase
  end

  function automatic string describe(input psp_pkg::psp_result_t r);
    return $sformatf({"kind %0d status %0d topic %0d nlen %0d char %h count %0d ",
                      "slot %0d id %h pstat %h offset %h tag %h last %b"},
                     r.kind, r.status, r.topic_number, r.name_length, r.name_char,
                     r.item_count, r.partition_slot, r.partition_id, r.partition_status,
                     r.log_offset, r.correlation_tag, r.last_of_run);
  endfunction

  psp_pkg::psp_result_t observed, predicted;
  int mismatches = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      observed.kind = kind;
      observed.status = status;
      observed.topic_number = topic_number;
      observed.name_length = name_length;
      observed.name_char = name_char;
      observed.item_count = item_count;
      observed.partition_slot = partition_slot;
      observed.partition_id = partition_id;
      observed.partition_status = partition_status;
      observed.log_offset = log_offset;
      observed.correlation_tag = correlation_tag;
      observed.last_of_run = last_of_run;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) $display("unexpected result: %s", describe(observed));
      end else begin
        predicted = pending_results.pop_front();
        if (observed !== predicted) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("expected: %s", describe(predicted));
            $display("actual:   %s", describe(observed));
          end
        end
      end
    end
  end

  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("produce_response_stream_parser: mismatch");
      $finish;
    end
  end

  initial begin
    clear_stream();
    // A lone final byte, an empty response, and a negative topic count.
    frame.push_back(8'hFF);
    queue_frame(0, 0);
    put_be(64'(32'd8), 4);
    put_be(64'(32'h8000_0000), 4);
    put_be(64'(32'd0), 4);
    queue_frame(0, 0);
    put_be(64'(32'd8), 4);
    put_be(64'(32'h7FFF_FFFF), 4);
    put_be(64'(32'hFFFF_FFFF), 4);
    queue_frame(0, 0);
    random_count = 0;
    while (random_count < RANDOM_BYTES) add_response();
    feed_total = feed.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (bytes_taken < feed_total) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("produce_response_stream_parser: match");
    end else begin
      $display("produce_response_stream_parser: mismatch");
    end
    $finish;
  end

endmodule
